// ===== rtl/core/sfd_pkg.sv =====
package sfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'hFE;

  // frame length counts the two sync bytes
  localparam int FRAME_LEN = 20;
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  // payload bytes 2..18 are held; byte 19 completes the frame
  localparam int HOLD_BYTES = FRAME_LEN - 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } q_item_t;

endpackage

// ===== rtl/core/sfd_front.sv =====
module sfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output sfd_pkg::q_item_t push_item,
  input  logic            q_full
);

  localparam logic [1:0] PH_HUNT      = 2'd0;
  localparam logic [1:0] PH_GOT_FIRST = 2'd1;
  localparam logic [1:0] PH_SYNCED    = 2'd2;

  logic [1:0]                 phase, phase_next;
  logic [sfd_pkg::CNT_W-1:0]  count, count_next;
  logic                       accept;
  logic                       is_last;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_last  = (count == sfd_pkg::LAST_IDX);

  assign push           = accept && (phase == PH_SYNCED);
  assign push_item.data = rx_byte;
  assign push_item.last = is_last;

  always_comb begin
    phase_next = phase;
    count_next = count;
    if (accept) begin
      unique case (phase)
        PH_GOT_FIRST: begin
          if (rx_byte == sfd_pkg::SYNC_SECOND) begin
            phase_next = PH_SYNCED;
            count_next = sfd_pkg::CNT_W'(2);
          end else begin
            // mismatching byte is dropped, not rechecked as a sync
            phase_next = PH_HUNT;
            count_next = '0;
          end
        end
        PH_SYNCED: begin
          if (is_last) begin
            phase_next = PH_HUNT;
            count_next = '0;
          end else begin
            count_next = count + sfd_pkg::CNT_W'(1);
          end
        end
        default: begin
          if (rx_byte == sfd_pkg::SYNC_FIRST) begin
            phase_next = PH_GOT_FIRST;
            count_next = sfd_pkg::CNT_W'(1);
          end else begin
            phase_next = PH_HUNT;
            count_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/sfd_queue.sv =====
module sfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfd_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output sfd_pkg::q_item_t q_head
);

  sfd_pkg::q_item_t           mem [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [sfd_pkg::QCNT_W-1:0] fill;

  assign full    = (fill == sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sfd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + sfd_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - sfd_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/sfd_back.sv =====
module sfd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  sfd_pkg::q_item_t q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       status_a,
  output logic [7:0]       status_b,
  output logic [7:0]       status_c,
  output logic [7:0]       status_d,
  output logic [7:0]       status_e,
  output logic [7:0]       status_f,
  output logic [15:0]      chan_one,
  output logic [15:0]      chan_two,
  output logic [15:0]      chan_three,
  output logic [15:0]      chan_four,
  output logic [15:0]      chan_five,
  output logic [15:0]      chan_six
);

  // hold[0] is the newest byte; frame byte k (2..18) sits at hold[18-k]
  logic [7:0] hold [sfd_pkg::HOLD_BYTES];
  logic       out_free;
  logic       load;

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_valid && (!q_head.last || out_free);
  assign load     = pop && q_head.last;

  always_ff @(posedge clk) begin
    if (pop && !q_head.last) begin
      hold[0] <= q_head.data;
      for (int i = 1; i < sfd_pkg::HOLD_BYTES; i++) begin
        hold[i] <= hold[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_a   <= hold[16];
      status_b   <= hold[15];
      status_c   <= hold[14];
      status_d   <= hold[13];
      status_e   <= hold[12];
      status_f   <= hold[11];
      chan_one   <= {hold[10], hold[9]};
      chan_two   <= {hold[8], hold[7]};
      chan_three <= {hold[6], hold[5]};
      chan_four  <= {hold[4], hold[3]};
      chan_five  <= {hold[2], hold[1]};
      chan_six   <= {hold[0], q_head.data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sync_framed_packet_deframer_core.sv =====
// Deframer for a 0xFF 0xFE sync word followed by a 20-byte frame (sync
// included). One byte is taken per cycle while in_stall is low; the front
// tracks sync and frame position, and a 4-entry queue feeds the back end,
// which shifts payload bytes into a holding line and loads the output
// register on the 20th byte, once the output is free. A completed frame
// passes through the queue before it appears on the output. in_stall rises
// only when the queue is full, which happens only while a finished frame
// sits unclaimed behind out_stall; the back end keeps absorbing payload
// bytes meanwhile and blocks only on the next frame's final byte.
module sync_framed_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  status_a,
  output logic [7:0]  status_b,
  output logic [7:0]  status_c,
  output logic [7:0]  status_d,
  output logic [7:0]  status_e,
  output logic [7:0]  status_f,
  output logic [15:0] chan_one,
  output logic [15:0] chan_two,
  output logic [15:0] chan_three,
  output logic [15:0] chan_four,
  output logic [15:0] chan_five,
  output logic [15:0] chan_six
);

  logic             push;
  sfd_pkg::q_item_t push_item;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  sfd_pkg::q_item_t q_head;

  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_head    (q_head)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status_a   (status_a),
    .status_b   (status_b),
    .status_c   (status_c),
    .status_d   (status_d),
    .status_e   (status_e),
    .status_f   (status_f),
    .chan_one   (chan_one),
    .chan_two   (chan_two),
    .chan_three (chan_three),
    .chan_four  (chan_four),
    .chan_five  (chan_five),
    .chan_six   (chan_six)
  );

endmodule
